>>> src/lbg_pkg.sv
// Shared types, codes and helper functions for the LED bar graph animator.
package lbg_pkg;

  // Input command codes
  localparam logic [1:0] CMD_IDLE   = 2'd0;
  localparam logic [1:0] CMD_ACTIVE = 2'd1;
  localparam logic [1:0] CMD_BEGIN  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_SPEED = 2'd0;
  localparam logic [1:0] CFG_POWER = 2'd1;
  localparam logic [1:0] CFG_BARS  = 2'd2;

  localparam int IDLE_BARS_PER_LEVEL = 5;
  localparam int HALF_DIV            = 2;

  localparam int DIV_W     = 32;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  typedef enum logic [1:0] {
    ST_READY,
    ST_ISSUE,
    ST_WAIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [DIV_W-1:0] remainder;
  } div_rsp_t;

  typedef struct packed {
    logic       active;
    logic [5:0] n;
    logic [1:0] power;
    logic [3:0] local_cnt;
    logic       asc;
    logic [5:0] cycle;
  } mask_ctl_t;

  // Number of bars swept in idle mode: 5 per power level.
  function automatic logic [3:0] idle_span(input logic [1:0] power);
    return 4'(power) * 4'(IDLE_BARS_PER_LEVEL);
  endfunction

  // Center bar of the active sweep; n is at least one.
  function automatic logic [5:0] mid_bar(input logic [5:0] n);
    return 6'((n - 6'd1) / HALF_DIV);
  endfunction

endpackage

>>> src/lbg_if.sv
// Request channel interfaces: tick input and LED mask output.
interface lbg_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] now_ms;

  modport source (output valid, output cmd, output now_ms, input ready);
  modport sink   (input valid, input cmd, input now_ms, output ready);
endinterface

interface lbg_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] led_mask;

  modport source (output valid, output led_mask, input ready);
  modport sink   (input valid, input led_mask, output ready);
endinterface

>>> src/lbg_div.sv
// Restoring divider, one quotient bit per cycle.
module lbg_div (
  input  logic               clk,
  input  logic               rst_n,
  input  lbg_pkg::div_req_t  req,
  output lbg_pkg::div_rsp_t  rsp
);
  import lbg_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0]     quo_r;
  logic [DIV_W-1:0]     rem_r;
  logic [DIV_W-1:0]     dvs_r;
  logic [DIV_W:0]       shifted;
  logic [DIV_W:0]       diff;
  logic                 fit;

  assign shifted = {rem_r, quo_r[DIV_W-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign fit     = ~diff[DIV_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      // done pulses the cycle after the last quotient bit
      done_r <= busy_r && !req.start && (&cnt_r);
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (&cnt_r) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIV_W-2:0], fit};
      rem_r <= fit ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
    end
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule

>>> src/lbg_mask.sv
// Builds the LED mask for idle fill/drain and active center sweep.
module lbg_mask (
  input  lbg_pkg::mask_ctl_t ctl,
  output logic [31:0]        mask
);
  import lbg_pkg::*;

  logic [3:0] max_lit;
  logic [3:0] top;
  logic [5:0] center;
  logic [6:0] up_raw;
  logic [6:0] up;
  logic [6:0] down;
  logic [6:0] pw;

  always_comb begin
    max_lit = idle_span(ctl.power);
    top     = max_lit - ctl.local_cnt;
    center  = mid_bar(ctl.n);
    up_raw  = 7'(center) + 7'(ctl.cycle);
    up      = (up_raw >= 7'(ctl.n)) ? 7'(center) : up_raw;
    down    = 7'(center) - 7'(ctl.cycle);
    pw      = 7'(ctl.power);
  end

  always_comb begin
    logic [6:0] ii;
    logic       lit;
    mask = '0;
    for (int i = 0; i < 32; i++) begin
      ii = 7'(i);
      if (ctl.active) begin
        lit = (ii >= up && ii < up + pw) || (ii <= down && ii + pw > down);
      end else begin
        lit = ctl.asc ? (ii < 7'(ctl.local_cnt)) : (ii < 7'(top));
      end
      mask[i] = lit && (ii < 7'(ctl.n));
    end
  end

endmodule

>>> src/led_bargraph_animator_core.sv
// Idle ticks run two divisions and active ticks four, then the result is offered on out_ch.
// Each division runs on the shared radix-2 divider: issued in ST_ISSUE, awaited in ST_WAIT.
// One request in flight; the next tick is accepted only once out_ch has taken the result.
// Begin, unused and power-0 idle ticks give no result; active with no bars outputs an empty mask.
// Synchronous active-low reset: speed 100, power 0, bars 15, start time and flags cleared.
module led_bargraph_animator_core #(
  parameter int MAX_BARS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  lbg_in_if.sink            in_ch,
  lbg_out_if.source         out_ch,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_wdata
);
  import lbg_pkg::*;

  // config registers
  logic [15:0] speed_r;
  logic [1:0]  power_r;
  logic [5:0]  bars_r;

  // animation state
  logic [31:0] start_r, start_nxt;
  logic        active_r, active_nxt;
  logic        begun_r, begun_nxt;

  // sequencer
  state_t      state_r, state_nxt;
  logic [1:0]  phase_r;
  logic        mode_r;        // 1: active sweep, 0: idle fill/drain
  logic [31:0] elapsed_r;
  logic [31:0] tmp_r;         // last quotient (step or frame count)
  logic [31:0] mask_r;

  logic        accept;
  logic        last_phase;
  logic [15:0] speed_eff;
  logic [5:0]  n;
  logic [5:0]  center;
  logic [31:0] quot_fix;
  logic [31:0] mask_w;

  div_req_t    div_req;
  div_rsp_t    div_rsp;
  mask_ctl_t   mask_ctl;

  assign accept    = in_ch.valid && in_ch.ready;
  assign speed_eff = (speed_r == 16'd0) ? 16'd1 : speed_r;
  // effective bar count = min(bar_count, MAX_BARS)
  assign n         = ({1'b0, bars_r} < 7'(MAX_BARS)) ? bars_r : 6'(MAX_BARS);
  assign center    = mid_bar(n);
  assign last_phase = mode_r ? (phase_r == 2'd3) : (phase_r == 2'd1);
  // active step is max(1, speed / n)
  assign quot_fix  = (mode_r && phase_r == 2'd0 && div_rsp.quotient == '0) ?
                     32'd1 : div_rsp.quotient;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r <= 16'd100;
      power_r <= 2'd0;
      bars_r  <= 6'd15;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SPEED: speed_r <= cfg_wdata;
        CFG_POWER: power_r <= cfg_wdata[1:0];
        CFG_BARS:  bars_r  <= cfg_wdata[5:0];
        default: ;
      endcase
    end
  end

  // start time and mode flags update when a tick is taken
  always_comb begin
    start_nxt  = start_r;
    active_nxt = active_r;
    begun_nxt  = begun_r;
    if (accept) begin
      case (in_ch.cmd)
        CMD_BEGIN: begin
          if (!begun_r) begin
            start_nxt = in_ch.now_ms;
            begun_nxt = 1'b1;
          end
        end
        CMD_IDLE: begin
          if (active_r) begin
            start_nxt  = in_ch.now_ms;
            active_nxt = 1'b0;
          end
        end
        CMD_ACTIVE: begin
          if (!active_r) begin
            start_nxt  = in_ch.now_ms;
            active_nxt = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r  <= '0;
      active_r <= 1'b0;
      begun_r  <= 1'b0;
      state_r  <= ST_READY;
      phase_r  <= '0;
      mode_r   <= 1'b0;
    end else begin
      start_r  <= start_nxt;
      active_r <= active_nxt;
      begun_r  <= begun_nxt;
      state_r  <= state_nxt;
      if (accept) begin
        phase_r <= '0;
        mode_r  <= (in_ch.cmd == CMD_ACTIVE);
      end else if (state_r == ST_WAIT && div_rsp.done && !last_phase) begin
        phase_r <= phase_r + 2'd1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      elapsed_r <= in_ch.now_ms - start_nxt;
      mask_r    <= '0;   // cleared on each tick; sent as is for an active tick with no bars
    end
    if (state_r == ST_WAIT && div_rsp.done) begin
      tmp_r <= quot_fix;
      if (last_phase) mask_r <= mask_w;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_READY: begin
        if (accept) begin
          if (in_ch.cmd == CMD_IDLE && power_r != 2'd0) state_nxt = ST_ISSUE;
          else if (in_ch.cmd == CMD_ACTIVE) state_nxt = (n == 6'd0) ? ST_OUT : ST_ISSUE;
        end
      end
      ST_ISSUE: state_nxt = ST_WAIT;
      ST_WAIT: begin
        if (div_rsp.done) state_nxt = last_phase ? ST_OUT : ST_ISSUE;
      end
      ST_OUT: begin
        if (out_ch.ready) state_nxt = ST_READY;
      end
    endcase
  end

  // outputs and divider operand select
  //   idle:   elapsed/speed -> frames; frames/(5*power) -> pass parity, position
  //   active: speed/n -> step; elapsed/step -> frames; frames/n; q/(center+1) -> offset
  always_comb begin
    in_ch.ready     = (state_r == ST_READY);
    out_ch.valid    = (state_r == ST_OUT);
    out_ch.led_mask = mask_r;
    div_req.start   = (state_r == ST_ISSUE);
    unique case (phase_r)
      2'd0: begin
        div_req.dividend = mode_r ? 32'(speed_eff) : elapsed_r;
        div_req.divisor  = mode_r ? 32'(n) : 32'(speed_eff);
      end
      2'd1: begin
        div_req.dividend = mode_r ? elapsed_r : tmp_r;
        div_req.divisor  = mode_r ? tmp_r : 32'(idle_span(power_r));
      end
      2'd2: begin
        div_req.dividend = tmp_r;
        div_req.divisor  = 32'(n);
      end
      2'd3: begin
        div_req.dividend = tmp_r;
        div_req.divisor  = 32'(center) + 32'd1;
      end
    endcase
  end

  assign mask_ctl.active    = mode_r;
  assign mask_ctl.n         = n;
  assign mask_ctl.power     = power_r;
  assign mask_ctl.local_cnt = div_rsp.remainder[3:0];
  assign mask_ctl.asc       = ~div_rsp.quotient[0];
  assign mask_ctl.cycle     = div_rsp.remainder[5:0];

  lbg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  lbg_mask u_mask (
    .ctl  (mask_ctl),
    .mask (mask_w)
  );

endmodule
